[design/fekv_pkg.sv]
package fekv_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned ValueBitsDef = 32;

  localparam int unsigned ActionBits = 2;
  localparam int unsigned PortKeyBits = 32;
  localparam int unsigned PortValueBits = 32;
  localparam int unsigned CountPortBits = 5;

  typedef enum logic [ActionBits-1:0] {
    ACT_ADD   = 2'd0,
    ACT_DEL   = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_CLEAR = 2'd3
  } fekv_action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } fekv_state_e;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic add_shift;
    logic add_load;
    logic del;
    logic clr;
  } fekv_ctl_t;

endpackage

[design/fekv_cell.sv]
module fekv_cell #(
  parameter int unsigned KEY_BITS   = fekv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = fekv_pkg::ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fekv_pkg::fekv_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  prev_valid_i,
  input  logic                  hit_below_i,
  input  logic [VALUE_BITS-1:0] found_below_i,
  input  logic                  up_valid_i,
  input  logic [KEY_BITS-1:0]   up_key_i,
  input  logic [VALUE_BITS-1:0] up_data_i,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] found_o,
  output logic                  valid_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] data_o
);
  import fekv_pkg::*;

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] data_q, data_d;
  logic                  match;
  logic                  shift;
  logic                  load;

  assign match = valid_q && (key_q == key_i);
  assign shift = ctl_i.add_shift || (ctl_i.del && (hit_below_i || match));
  assign load  = ctl_i.add_load && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    priority if (ctl_i.clr) begin
      valid_d = 1'b0;
    end else if (shift) begin
      valid_d = up_valid_i;
      key_d   = up_key_i;
      data_d  = up_data_i;
    end else if (load) begin
      valid_d = 1'b1;
      key_d   = key_i;
      data_d  = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign hit_o   = hit_below_i || match;
  assign found_o = found_below_i | (match ? data_q : '0);
  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign data_o  = data_q;

endmodule

[design/fifo_evicting_key_value_table.sv]
// an accepted transaction is held in the input register; its result is registered
// when it executes; a new transaction is taken only once the last one has executed,
// and the cell row compares all keys and updates in the exec cycle
// a waiting result holds off exec, so only one more transaction is taken in meanwhile
// reset: asynchronous, active low; empties the table and drops any pending result
module fifo_evicting_key_value_table #(
  parameter int unsigned CAPACITY   = fekv_pkg::CapacityDef,
  parameter int unsigned KEY_BITS   = fekv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = fekv_pkg::ValueBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [fekv_pkg::ActionBits-1:0]       action_i,
  input  logic [fekv_pkg::PortKeyBits-1:0]      key_i,
  input  logic [fekv_pkg::PortValueBits-1:0]    value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  present_o,
  output logic [fekv_pkg::PortValueBits-1:0]    found_value_o,
  output logic [fekv_pkg::CountPortBits-1:0]    live_count_o
);
  import fekv_pkg::*;

  localparam int unsigned CountBits = $clog2(CAPACITY + 1);

  fekv_state_e state_q, state_d;
  fekv_action_e          op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CountBits-1:0]  count_q, count_d;

  logic                            out_valid_q, out_valid_d;
  logic                            present_q;
  logic [PortValueBits-1:0]        found_q;
  logic [CountPortBits-1:0]        live_q;

  logic                  accept;
  logic                  exec;
  logic                  any_hit;
  logic                  full;
  fekv_ctl_t             ctl;

  logic                  hit_w   [CAPACITY+1];
  logic [VALUE_BITS-1:0] found_w [CAPACITY+1];
  logic                  valid_w [CAPACITY+1];
  logic [KEY_BITS-1:0]   key_w   [CAPACITY+1];
  logic [VALUE_BITS-1:0] data_w  [CAPACITY+1];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign exec       = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign hit_w[0]   = 1'b0;
  assign found_w[0] = '0;
  assign any_hit    = hit_w[CAPACITY];
  assign full       = valid_w[CAPACITY-1];

  // entry offered to the top cell when the row shifts down
  assign valid_w[CAPACITY] = (op_q == ACT_ADD);
  assign key_w[CAPACITY]   = key_q;
  assign data_w[CAPACITY]  = value_q;

  always_comb begin
    ctl.add_shift = exec && (op_q == ACT_ADD) && !any_hit && full;
    ctl.add_load  = exec && (op_q == ACT_ADD) && !any_hit && !full;
    ctl.del       = exec && (op_q == ACT_DEL) && any_hit;
    ctl.clr       = exec && (op_q == ACT_CLEAR);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid_w[i-1];
    end
    fekv_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .value_i      (value_q),
      .prev_valid_i (prev_valid),
      .hit_below_i  (hit_w[i]),
      .found_below_i(found_w[i]),
      .up_valid_i   (valid_w[i+1]),
      .up_key_i     (key_w[i+1]),
      .up_data_i    (data_w[i+1]),
      .hit_o        (hit_w[i+1]),
      .found_o      (found_w[i+1]),
      .valid_o      (valid_w[i]),
      .key_o        (key_w[i]),
      .data_o       (data_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    priority if (ctl.clr) begin
      count_d = '0;
    end else if (ctl.add_load) begin
      count_d = count_q + CountBits'(1);
    end else if (ctl.del) begin
      count_d = count_q - CountBits'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= fekv_action_e'(action_i);
      key_q   <= KEY_BITS'(key_i);
      value_q <= VALUE_BITS'(value_i);
    end
    if (exec) begin
      present_q <= any_hit;
      found_q   <= (op_q == ACT_FIND) ? PortValueBits'(found_w[CAPACITY]) : '0;
      live_q    <= CountPortBits'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign present_o     = present_q;
  assign found_value_o = found_q;
  assign live_count_o  = live_q;

endmodule

[design/fekv_checker.sv]
module fekv_checker #(
  parameter int unsigned CAPACITY = fekv_pkg::CapacityDef
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic                                  present_o,
  input logic [fekv_pkg::PortValueBits-1:0]    found_value_o,
  input logic [fekv_pkg::CountPortBits-1:0]    live_count_o
);
  import fekv_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(present_o)
      && $stable(found_value_o) && $stable(live_count_o))
    else $error("stalled result changed");

  // an accepted transaction blocks the input until it is executed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after a transaction");

  // a nonzero value is only returned on a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (found_value_o != '0) |-> present_o)
    else $error("value returned without a hit");

  // count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(live_count_o) <= int'(CAPACITY)))
    else $error("live count above capacity");

endmodule

bind fifo_evicting_key_value_table fekv_checker #(.CAPACITY(CAPACITY)) u_fekv_checker (.*);
